@@ hw/rtl/batch_norm_forward_core_assert.svh @@
// Assertion macros shared by the batch norm forward RTL.
// Expects clk and rst_n in the scope of use.
`ifndef BATCH_NORM_FORWARD_CORE_ASSERT_SVH
`define BATCH_NORM_FORWARD_CORE_ASSERT_SVH

// same-cycle implication
`define BNF_CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BNF_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bnf_pkg.sv @@
// Package for the batch norm forward core: beat types, codes, constants.
// No dependencies.
`default_nettype none
package bnf_pkg;

  localparam int TBL_DEPTH = 64;
  localparam int CH_W      = 6;
  localparam int DIV_W     = 64;
  localparam int DEN_W     = 34;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_DRAIN  = 2'd2;

  localparam logic [7:0] REG_MODE     = 8'd0;
  localparam logic [7:0] REG_EPSILON  = 8'd1;
  localparam logic [7:0] REG_MOMENTUM = 8'd2;
  localparam logic [7:0] REG_GSIZE    = 8'd3;

  localparam logic [15:0] EPS_RST   = 16'd1;
  localparam logic [15:0] MOM_RST   = 16'd58982;
  localparam logic [10:0] GSIZE_RST = 11'd1024;

  localparam logic signed [15:0] ONE_Q88   = 16'sd256;
  localparam logic [31:0]        ONE_Q1616 = 32'd65536;
  localparam logic [23:0]        INV_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [CH_W-1:0]    channel;
    logic signed [15:0] sample_value;
    logic signed [15:0] scale_value;
    logic signed [15:0] shift_value;
  } bnf_in_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [CH_W-1:0]    out_channel;
    logic               out_last;
  } bnf_out_t;

  typedef struct packed {
    logic start;
    logic op_sqrt;
  } bnf_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bnf_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/bnf_divsqrt.sv @@
// Shared iterative unit: 64-bit restoring divide or integer square root.
// Depends on bnf_pkg and the assertion macro header.
`default_nettype none
`include "batch_norm_forward_core_assert.svh"
module bnf_divsqrt import bnf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bnf_ctl_t         ctl,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output bnf_sts_t              sts,
  output logic [DIV_W-1:0]      res
);

  logic             busy_r, done_r, sqrt_r;
  logic [5:0]       cnt_r;
  logic [DIV_W-1:0] q_r, r_r, rbit_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DIV_W-1:0] trial;
  logic             last;

  assign rem_sh = {rem_r[DEN_W-1:0], q_r[DIV_W-1]};
  assign trial  = r_r + rbit_r;
  assign last   = sqrt_r ? (cnt_r == 6'd31) : (cnt_r == 6'd63);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
    if (ctl.start) begin
      sqrt_r <= ctl.op_sqrt;
      cnt_r  <= '0;
      q_r    <= num;
      den_r  <= den;
      rem_r  <= '0;
      r_r    <= '0;
      rbit_r <= DIV_W'(1) << 62;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (sqrt_r) begin
        if (q_r >= trial) begin
          q_r <= q_r - trial;
          r_r <= (r_r >> 1) + rbit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
      end else begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          q_r   <= {q_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = sqrt_r ? r_r : q_r;

  `BNF_CHK_NXT(a_start_busy, ctl.start, busy_r, "unit not busy after start")
  `BNF_CHK_IMP(a_done_idle, done_r, !busy_r, "done while busy")
  `BNF_CHK_IMP(a_no_restart, busy_r, !ctl.start, "start while busy")

endmodule
`default_nettype wire

@@ hw/rtl/batch_norm_forward_core.sv @@
// Batch norm forward core (Q8.8): per-channel tables, group buffer, sequencer.
// Depends on bnf_pkg, bnf_divsqrt and the assertion macro header.
//
// Input beats (in_valid/in_stall, bnf_in_t): load scale/shift, sample, drain.
// Result beats (out_valid/out_stall, bnf_out_t) come from inference samples
// and drain beats; loads and training samples give none.
// Config writes (cfg_valid/cfg_ready, always ready): index 0 mode,
// 1 epsilon, 2 momentum, 3 group size; write only while the core is idle.
// Stalls: a load, an ignored beat or a training sample that does not close
// its group is taken without raising in_stall. An inference sample holds
// in_stall mainly for a 64-step divide and a 32-step square root in the
// shared unit. The sample that closes a group of n holds it through two
// buffer walks (sum, then squared deviations), three divides and a square
// root. A drain beat holds it through S_DRN_RD, S_N1, S_N2, S_N3 and S_OUT.
// in_stall is high while a beat is being worked on. A finished result sits
// in the output register; a stalled receiver holds it there and the core
// waits in S_OUT, with in_stall high, before writing the next one.
// Synchronous reset restores table contents through per-entry valid bits,
// so no clearing pass is needed.
`default_nettype none
`include "batch_norm_forward_core_assert.svh"
module batch_norm_forward_core import bnf_pkg::*; #(
  parameter int CHANNELS  = 64,
  parameter int GROUP_MAX = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire bnf_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output bnf_out_t     out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam int CW = $clog2(GROUP_MAX + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SUM_RD  = 5'd1;
  localparam logic [4:0] S_SUM_ACC = 5'd2;
  localparam logic [4:0] S_MEAN    = 5'd3;
  localparam logic [4:0] S_MEAN_W  = 5'd4;
  localparam logic [4:0] S_SQ_RD   = 5'd5;
  localparam logic [4:0] S_SQ_MUL  = 5'd6;
  localparam logic [4:0] S_SQ_ACC  = 5'd7;
  localparam logic [4:0] S_VAR     = 5'd8;
  localparam logic [4:0] S_VAR_W   = 5'd9;
  localparam logic [4:0] S_MM1     = 5'd10;
  localparam logic [4:0] S_MM2     = 5'd11;
  localparam logic [4:0] S_MM3     = 5'd12;
  localparam logic [4:0] S_MV1     = 5'd13;
  localparam logic [4:0] S_MV2     = 5'd14;
  localparam logic [4:0] S_MV3     = 5'd15;
  localparam logic [4:0] S_INV     = 5'd16;
  localparam logic [4:0] S_INV_DW  = 5'd17;
  localparam logic [4:0] S_INV_SQ  = 5'd18;
  localparam logic [4:0] S_INV_SW  = 5'd19;
  localparam logic [4:0] S_INF_RD  = 5'd20;
  localparam logic [4:0] S_DRN_RD  = 5'd21;
  localparam logic [4:0] S_N1      = 5'd22;
  localparam logic [4:0] S_N2      = 5'd23;
  localparam logic [4:0] S_N3      = 5'd24;
  localparam logic [4:0] S_OUT     = 5'd25;

  // config
  logic        mode_r;
  logic [15:0] eps_r, mom_r;
  logic [10:0] gsize_r;

  // control
  logic [4:0]      state_r;
  logic [CW-1:0]   cnt_r, idx_r, drain_idx_r;
  logic            draining_r, use_grp_r;
  logic [CH_W-1:0] ch_r, group_ch_r;
  logic            out_valid_r;
  bnf_out_t        out_r;

  // datapath
  logic signed [15:0] x_r, gmean_r, mmean_r;
  logic [23:0]        ginv_r, inv_r;
  logic [31:0]        var_r;
  logic signed [63:0] acc_r;
  logic signed [59:0] prod_r;
  logic signed [15:0] y_r;

  // memories
  logic signed [15:0] buf_mem [GROUP_MAX];
  logic signed [15:0] buf_q;
  logic [31:0]        par_mem [TBL_DEPTH];
  logic [31:0]        par_q;
  logic [47:0]        st_mem  [TBL_DEPTH];
  logic [47:0]        st_q;
  logic [TBL_DEPTH-1:0] pv_r, sv_r;
  logic               pv_q, sv_q;

  logic [AW-1:0]   buf_raddr;
  logic [CH_W-1:0] tbl_raddr;
  logic            acc_in, ld_we, smp_we, st_we;
  logic            bad_ch;
  logic [CW-1:0]   size_eff;
  logic [CW-1:0]   cnt_inc;

  logic signed [15:0] gamma, beta, om;
  logic [31:0]        ov;
  logic signed [15:0] x_sel, m_sel;
  logic [23:0]        inv_sel;
  logic signed [16:0] d_sq, d_n;
  logic signed [41:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [59:0] prod_w;
  logic [16:0]        w_new;
  logic [32:0]        v_sum;
  logic signed [63:0] mm_t, n_t, y64;
  logic signed [15:0] y_sat;
  logic [31:0]        var_sat;
  logic [23:0]        inv_sat;

  bnf_ctl_t         u_ctl;
  bnf_sts_t         u_sts;
  logic [DIV_W-1:0] u_num, u_res;
  logic [DEN_W-1:0] u_den;

  assign in_stall  = (state_r != S_IDLE);
  assign acc_in    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign bad_ch  = (int'(in_data.channel) >= CHANNELS);
  assign cnt_inc = cnt_r + CW'(1);
  always_comb begin
    if (gsize_r == 11'd0) begin
      size_eff = CW'(1);
    end else if (int'(gsize_r) > GROUP_MAX) begin
      size_eff = CW'(GROUP_MAX);
    end else begin
      size_eff = CW'(gsize_r);
    end
  end

  assign ld_we  = acc_in && in_data.cmd == CMD_LOAD && !bad_ch;
  assign smp_we = acc_in && in_data.cmd == CMD_SAMPLE && !bad_ch && !mode_r
                  && !draining_r && (int'(cnt_r) < GROUP_MAX);
  assign st_we  = (state_r == S_MV3);

  assign buf_raddr = (state_r == S_SUM_RD || state_r == S_SQ_RD) ?
                     idx_r[AW-1:0] : drain_idx_r[AW-1:0];
  assign tbl_raddr = use_grp_r ? group_ch_r : ch_r;

  always_ff @(posedge clk) begin
    if (smp_we) begin
      buf_mem[cnt_r[AW-1:0]] <= in_data.sample_value;
    end
    buf_q <= buf_mem[buf_raddr];
    if (ld_we) begin
      par_mem[in_data.channel] <= {in_data.scale_value, in_data.shift_value};
    end
    par_q <= par_mem[tbl_raddr];
    pv_q  <= pv_r[tbl_raddr];
    if (st_we) begin
      st_mem[group_ch_r] <= {mmean_r, mm_t[47:16]};
    end
    st_q <= st_mem[tbl_raddr];
    sv_q <= sv_r[tbl_raddr];
  end

  // effective table values, reset contents where never written
  assign gamma = pv_q ? $signed(par_q[31:16]) : ONE_Q88;
  assign beta  = pv_q ? $signed(par_q[15:0]) : 16'sd0;
  assign om    = sv_q ? $signed(st_q[47:32]) : 16'sd0;
  assign ov    = sv_q ? st_q[31:0] : ONE_Q1616;

  assign x_sel   = use_grp_r ? buf_q : x_r;
  assign m_sel   = use_grp_r ? gmean_r : om;
  assign inv_sel = use_grp_r ? ginv_r : inv_r;
  assign d_sq    = 17'(buf_q) - 17'(gmean_r);
  assign d_n     = 17'(x_sel) - 17'(m_sel);
  assign w_new   = 17'd65536 - 17'(mom_r);
  assign v_sum   = (use_grp_r ? {1'b0, var_r} : {1'b0, ov}) + 33'(eps_r);

  always_comb begin
    case (state_r)
      S_SQ_MUL: begin
        mul_a = 42'(d_sq);
        mul_b = 18'(d_sq);
      end
      S_MM1: begin
        mul_a = 42'(om);
        mul_b = $signed({2'b00, mom_r});
      end
      S_MM2: begin
        mul_a = 42'(gmean_r);
        mul_b = $signed({1'b0, w_new});
      end
      S_MV1: begin
        mul_a = $signed({10'd0, ov});
        mul_b = $signed({2'b00, mom_r});
      end
      S_MV2: begin
        mul_a = $signed({10'd0, var_r});
        mul_b = $signed({1'b0, w_new});
      end
      S_N1: begin
        mul_a = $signed({18'd0, inv_sel});
        mul_b = 18'(gamma);
      end
      S_N2: begin
        mul_a = $signed(prod_r[41:0]);
        mul_b = 18'(d_n);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_w = mul_a * mul_b;

  assign mm_t = acc_r + 64'(prod_r) + 64'sd32768;
  assign n_t  = 64'(prod_r) + (64'(beta) <<< 24) + 64'sd8388608;
  assign y64  = n_t >>> 24;
  always_comb begin
    if (y64 > 64'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (y64 < -64'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y64[15:0];
    end
  end
  assign var_sat = (u_res[63:32] != '0) ? 32'hFFFFFFFF : u_res[31:0];
  assign inv_sat = (u_res[63:24] != '0) ? INV_MAX : u_res[23:0];

  always_comb begin
    u_ctl.start   = 1'b0;
    u_ctl.op_sqrt = 1'b0;
    u_num         = '0;
    u_den         = '0;
    case (state_r)
      S_MEAN: begin
        u_ctl.start = 1'b1;
        u_num = $unsigned(acc_r <<< 1) + DIV_W'(cnt_r) + (DIV_W'(cnt_r) << 17);
        u_den = DEN_W'(cnt_r) << 1;
      end
      S_VAR: begin
        u_ctl.start = 1'b1;
        u_num = $unsigned(acc_r) + DIV_W'(cnt_r >> 1);
        u_den = DEN_W'(cnt_r);
      end
      S_INV: begin
        u_ctl.start = (v_sum != '0);
        u_num = DIV_W'(1) << 48;
        u_den = DEN_W'(v_sum);
      end
      S_INV_SQ: begin
        u_ctl.start   = 1'b1;
        u_ctl.op_sqrt = 1'b1;
        u_num         = u_res;
      end
      default: begin
        u_ctl.start = 1'b0;
      end
    endcase
  end

  bnf_divsqrt u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (u_ctl),
    .num  (u_num),
    .den  (u_den),
    .sts  (u_sts),
    .res  (u_res)
  );

  always_ff @(posedge clk) begin
    prod_r <= prod_w;
    if (!rst_n) begin
      mode_r      <= 1'b0;
      eps_r       <= EPS_RST;
      mom_r       <= MOM_RST;
      gsize_r     <= GSIZE_RST;
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      drain_idx_r <= '0;
      draining_r  <= 1'b0;
      use_grp_r   <= 1'b0;
      ch_r        <= '0;
      group_ch_r  <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= '0;
      sv_r        <= '0;
      gmean_r     <= '0;
      ginv_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     mode_r  <= cfg_data[0];
          REG_EPSILON:  eps_r   <= cfg_data;
          REG_MOMENTUM: mom_r   <= cfg_data;
          REG_GSIZE:    gsize_r <= cfg_data[10:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (ld_we) begin
        pv_r[in_data.channel] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            ch_r <= in_data.channel;
            x_r  <= in_data.sample_value;
            if (in_data.cmd == CMD_DRAIN) begin
              if (draining_r) begin
                use_grp_r <= 1'b1;
                state_r   <= S_DRN_RD;
              end
            end else if (in_data.cmd == CMD_SAMPLE && !bad_ch) begin
              if (mode_r) begin
                use_grp_r <= 1'b0;
                state_r   <= S_INF_RD;
              end else if (!draining_r) begin
                if (cnt_r == '0) begin
                  group_ch_r <= in_data.channel;
                end
                if (smp_we) begin
                  cnt_r <= cnt_inc;
                end
                if ((smp_we ? cnt_inc : cnt_r) >= size_eff) begin
                  use_grp_r <= 1'b1;
                  acc_r   <= '0;
                  idx_r   <= '0;
                  state_r <= S_SUM_RD;
                end
              end
            end
          end
        end
        S_SUM_RD: state_r <= S_SUM_ACC;
        S_SUM_ACC: begin
          acc_r <= acc_r + 64'(buf_q);
          idx_r <= idx_r + CW'(1);
          state_r <= (idx_r + CW'(1) >= cnt_r) ? S_MEAN : S_SUM_RD;
        end
        S_MEAN: state_r <= S_MEAN_W;
        S_MEAN_W: begin
          if (u_sts.done) begin
            gmean_r <= $signed(u_res[15:0]);
            acc_r   <= '0;
            idx_r   <= '0;
            state_r <= S_SQ_RD;
          end
        end
        S_SQ_RD:  state_r <= S_SQ_MUL;
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          acc_r <= acc_r + 64'(prod_r);
          idx_r <= idx_r + CW'(1);
          state_r <= (idx_r + CW'(1) >= cnt_r) ? S_VAR : S_SQ_RD;
        end
        S_VAR: state_r <= S_VAR_W;
        S_VAR_W: begin
          if (u_sts.done) begin
            var_r   <= var_sat;
            state_r <= S_MM1;
          end
        end
        S_MM1: state_r <= S_MM2;
        S_MM2: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_MM3;
        end
        S_MM3: begin
          mmean_r <= mm_t[31:16];
          state_r <= S_MV1;
        end
        S_MV1: state_r <= S_MV2;
        S_MV2: begin
          acc_r   <= 64'(prod_r);
          state_r <= S_MV3;
        end
        S_MV3: begin
          sv_r[group_ch_r] <= 1'b1;
          state_r <= S_INV;
        end
        S_INF_RD: state_r <= S_INV;
        S_INV: begin
          if (v_sum == '0) begin
            if (use_grp_r) begin
              ginv_r      <= INV_MAX;
              draining_r  <= 1'b1;
              drain_idx_r <= '0;
              state_r     <= S_IDLE;
            end else begin
              inv_r   <= INV_MAX;
              state_r <= S_N1;
            end
          end else begin
            state_r <= S_INV_DW;
          end
        end
        S_INV_DW: begin
          if (u_sts.done) begin
            state_r <= S_INV_SQ;
          end
        end
        S_INV_SQ: state_r <= S_INV_SW;
        S_INV_SW: begin
          if (u_sts.done) begin
            if (use_grp_r) begin
              ginv_r      <= inv_sat;
              draining_r  <= 1'b1;
              drain_idx_r <= '0;
              state_r     <= S_IDLE;
            end else begin
              inv_r   <= inv_sat;
              state_r <= S_N1;
            end
          end
        end
        S_DRN_RD: state_r <= S_N1;
        S_N1: state_r <= S_N2;
        S_N2: state_r <= S_N3;
        S_N3: begin
          y_r     <= y_sat;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_r.out_value   <= y_r;
            state_r           <= S_IDLE;
            if (use_grp_r) begin
              out_r.out_channel <= group_ch_r;
              out_r.out_last    <= (drain_idx_r + CW'(1) >= cnt_r);
              if (drain_idx_r + CW'(1) >= cnt_r) begin
                draining_r  <= 1'b0;
                cnt_r       <= '0;
                drain_idx_r <= '0;
              end else begin
                drain_idx_r <= drain_idx_r + CW'(1);
              end
            end else begin
              out_r.out_channel <= ch_r;
              out_r.out_last    <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BNF_CHK_IMP(a_drain_cnt, draining_r, cnt_r != '0, "draining an empty group")
  `BNF_CHK_IMP(a_drain_idx, draining_r, drain_idx_r < cnt_r, "drain index past group")
  `BNF_CHK_IMP(a_cnt_max, 1'b1, int'(cnt_r) <= GROUP_MAX, "group count overflow")
  `BNF_CHK_IMP(a_unit_idle, state_r == S_IDLE, !u_sts.busy, "unit busy while idle")

endmodule
`default_nettype wire
